[design/triangle_tangent_basis_assert.svh]
// Assertion macros for the tangent basis block.
`ifndef TRIANGLE_TANGENT_BASIS_ASSERT_SVH
`define TRIANGLE_TANGENT_BASIS_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define TTB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the cycle after the antecedent.
`define TTB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/ttb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttb_pkg
// Types and constants shared by the tangent basis block.
// ----------------------------------------------------------------------------
package ttb_pkg;

	localparam int CoordW   = 24;
	localparam int IndexW   = 16;
	localparam int OutW     = 32;
	localparam int OutFrac  = 16;
	localparam int DeltaW   = CoordW + 1;     // 25
	localparam int ProdW    = 2 * DeltaW;     // 50
	localparam int NumW     = ProdW + 1;      // 51
	localparam int MagW     = NumW;           // magnitudes of num and det
	localparam int QuotW    = OutW + 1;       // 33, covers 2^32 clamp
	localparam int DivSteps = MagW + OutFrac; // 67 restoring steps
	localparam int StepW    = 7;

	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_MUL,
		ST_DIV,
		ST_EMIT
	} ttb_state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} ttb_div_ctl_t;

endpackage

[design/triangle_tangent_basis.sv]
`timescale 1ns / 1ps
// The first two corner beats are taken one per cycle. The third starts
// shared multiplier work (det, six numerators) and then, unless the
// triangle is degenerate, six divisions on the single divider (start,
// one quotient bit per restoring step, done); degenerate ones go to emit.
// No new triangle is taken until all three result beats have been accepted.
// Reset (arst_n low) clears the sequencer and corner count; corner data is not.
// ----------------------------------------------------------------------------
// triangle_tangent_basis
// Tangent and bitangent per triangle from positions and texture coordinates.
// ----------------------------------------------------------------------------
module triangle_tangent_basis import ttb_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [IndexW-1:0]        vertex_index,
	input  logic signed [CoordW-1:0] pos_x,
	input  logic signed [CoordW-1:0] pos_y,
	input  logic signed [CoordW-1:0] pos_z,
	input  logic signed [CoordW-1:0] tex_u,
	input  logic signed [CoordW-1:0] tex_v,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [IndexW-1:0]        corner_index,
	output logic signed [OutW-1:0]   tangent_x,
	output logic signed [OutW-1:0]   tangent_y,
	output logic signed [OutW-1:0]   tangent_z,
	output logic signed [OutW-1:0]   bitangent_x,
	output logic signed [OutW-1:0]   bitangent_y,
	output logic signed [OutW-1:0]   bitangent_z,
	output logic                     degenerate,
	output logic                     last_of_triangle
);

`include "triangle_tangent_basis_assert.svh"

	ttb_state_t state_q, state_nx;
	logic [1:0] corner_q;       // corners held, 0..2
	logic [1:0] emit_q;         // result beat within triangle
	logic [3:0] mstep_q;        // multiply step
	logic [2:0] dstep_q;        // division index 0..5
	logic       dstarted_q;

	// held corners: positions in slot 0 and slot 1, indices for all three
	logic [IndexW-1:0]        idx_q [3];
	logic signed [CoordW-1:0] px_q [2], py_q [2], pz_q [2], pu_q [2], pv_q [2];

	// deltas
	logic signed [DeltaW-1:0] dp1_q [3], dp2_q [3];
	logic signed [DeltaW-1:0] du1_q, dv1_q, du2_q, dv2_q;

	// products and numerators
	logic signed [ProdW-1:0]  prod_q;
	logic signed [NumW-1:0]   acc_q;
	logic signed [NumW-1:0]   num_q [6];
	logic signed [NumW-1:0]   det_q;
	logic signed [OutW-1:0]   res_q [6];
	logic                     degen_q;

	logic in_acc, out_acc;
	logic signed [DeltaW-1:0] ma, mb;
	logic div_start;
	ttb_div_ctl_t div_ctl;
	logic signed [OutW-1:0] div_quot;

	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_COLLECT: if (in_acc && corner_q == 2'd2) state_nx = ST_MUL;
			ST_MUL:     if (mstep_q == 4'd14) state_nx = degen_q ? ST_EMIT : ST_DIV;
			ST_DIV:     if (div_ctl.done && dstep_q == 3'd5) state_nx = ST_EMIT;
			ST_EMIT:    if (out_acc && emit_q == 2'd2) state_nx = ST_COLLECT;
			default:    state_nx = ST_COLLECT;
		endcase
	end

	// outputs
	always_comb begin
		in_stall  = (state_q != ST_COLLECT);
		out_valid = (state_q == ST_EMIT);
		div_start = (state_q == ST_DIV) && !dstarted_q;
	end

	// Shared multiplier operand select. Steps 0..1: det terms; then six
	// numerators, two products each. The product is registered and read in the next cycle.
	always_comb begin
		ma = '0;
		mb = '0;
		case (mstep_q)
			4'd0:  begin ma = du1_q;    mb = dv2_q; end
			4'd1:  begin ma = dv1_q;    mb = du2_q; end
			4'd2:  begin ma = dp1_q[0]; mb = dv2_q; end
			4'd3:  begin ma = dp2_q[0]; mb = dv1_q; end
			4'd4:  begin ma = dp1_q[1]; mb = dv2_q; end
			4'd5:  begin ma = dp2_q[1]; mb = dv1_q; end
			4'd6:  begin ma = dp1_q[2]; mb = dv2_q; end
			4'd7:  begin ma = dp2_q[2]; mb = dv1_q; end
			4'd8:  begin ma = dp2_q[0]; mb = du1_q; end
			4'd9:  begin ma = dp1_q[0]; mb = du2_q; end
			4'd10: begin ma = dp2_q[1]; mb = du1_q; end
			4'd11: begin ma = dp1_q[1]; mb = du2_q; end
			4'd12: begin ma = dp2_q[2]; mb = du1_q; end
			4'd13: begin ma = dp1_q[2]; mb = du2_q; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_COLLECT;
			corner_q   <= '0;
			emit_q     <= '0;
			mstep_q    <= '0;
			dstep_q    <= '0;
			dstarted_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (in_acc) corner_q <= (corner_q == 2'd2) ? 2'd0 : corner_q + 2'd1;
			if (state_q == ST_MUL) mstep_q <= mstep_q + 4'd1;
			else mstep_q <= '0;
			if (state_q == ST_DIV) begin
				dstarted_q <= div_ctl.done ? 1'b0 : 1'b1;
				if (div_ctl.done) dstep_q <= dstep_q + 3'd1;
			end else begin
				dstarted_q <= 1'b0;
				dstep_q    <= '0;
			end
			if (out_acc) emit_q <= (emit_q == 2'd2) ? 2'd0 : emit_q + 2'd1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_q[corner_q] <= vertex_index;
			if (corner_q != 2'd2) begin
				px_q[corner_q[0]] <= pos_x;
				py_q[corner_q[0]] <= pos_y;
				pz_q[corner_q[0]] <= pos_z;
				pu_q[corner_q[0]] <= tex_u;
				pv_q[corner_q[0]] <= tex_v;
			end else begin
				dp1_q[0] <= DeltaW'(px_q[1]) - DeltaW'(px_q[0]);
				dp1_q[1] <= DeltaW'(py_q[1]) - DeltaW'(py_q[0]);
				dp1_q[2] <= DeltaW'(pz_q[1]) - DeltaW'(pz_q[0]);
				dp2_q[0] <= DeltaW'(pos_x) - DeltaW'(px_q[0]);
				dp2_q[1] <= DeltaW'(pos_y) - DeltaW'(py_q[0]);
				dp2_q[2] <= DeltaW'(pos_z) - DeltaW'(pz_q[0]);
				du1_q <= DeltaW'(pu_q[1]) - DeltaW'(pu_q[0]);
				dv1_q <= DeltaW'(pv_q[1]) - DeltaW'(pv_q[0]);
				du2_q <= DeltaW'(tex_u) - DeltaW'(pu_q[0]);
				dv2_q <= DeltaW'(tex_v) - DeltaW'(pv_q[0]);
			end
		end
		if (state_q == ST_MUL) begin
			prod_q <= ma * mb;
			// product of an even step is latched in the next step; that of an odd step is subtracted
			if (mstep_q != 4'd0) begin
				if (mstep_q[0]) acc_q <= NumW'(prod_q);
				else begin
					if (mstep_q == 4'd2) begin
						det_q   <= acc_q - NumW'(prod_q);
						degen_q <= (acc_q == NumW'(prod_q));
					end else begin
						num_q[3'(mstep_q / 2 - 4'd2)] <= acc_q - NumW'(prod_q);
					end
				end
			end
		end
		if (div_ctl.done) res_q[dstep_q] <= div_quot;
		if (state_q == ST_MUL && mstep_q == 4'd14 && degen_q) begin
			for (int i = 0; i < 6; i++) res_q[i] <= '0;
		end
	end

	ttb_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q[dstep_q]),
		.den    (det_q),
		.ctl    (div_ctl),
		.quot   (div_quot)
	);

	assign corner_index     = idx_q[emit_q];
	assign tangent_x        = res_q[0];
	assign tangent_y        = res_q[1];
	assign tangent_z        = res_q[2];
	assign bitangent_x      = res_q[3];
	assign bitangent_y      = res_q[4];
	assign bitangent_z      = res_q[5];
	assign degenerate       = degen_q;
	assign last_of_triangle = (emit_q == 2'd2);

	`TTB_ASSERT_IMP(a_no_in_while_out, clk, arst_n, out_valid, in_stall, "input taken during emit")
	`TTB_ASSERT_IMP(a_div_idle_in_collect, clk, arst_n, state_q == ST_COLLECT, !div_ctl.done, "divider done while collecting")
	`TTB_ASSERT_NEXT(a_third_corner_starts, clk, arst_n, in_acc && corner_q == 2'd2, state_q == ST_MUL, "third corner did not start work")

endmodule

[design/ttb_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttb_divider
// Restoring divider, one quotient bit per cycle: |num| * 2^16 / |den|,
// truncated, signed result saturated to 32 bits.
// ----------------------------------------------------------------------------
module ttb_divider import ttb_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NumW-1:0]  num,
	input  logic signed [NumW-1:0]  den,
	output ttb_div_ctl_t            ctl,
	output logic signed [OutW-1:0]  quot
);

	logic [MagW-1:0]          n_q;      // dividend bits still to shift in
	logic [MagW-1:0]          d_q;
	logic [MagW:0]            rem_q;
	logic [DivSteps-1:0]      q_q;
	logic [StepW-1:0]         cnt_q;
	logic                     neg_q;
	logic                     busy_q;
	logic                     done_q;
	logic [MagW:0]            shifted;
	logic                     fits;
	logic [MagW-1:0]          n_abs;
	logic [MagW-1:0]          d_abs;
	logic [QuotW-1:0]         mag;

	assign n_abs   = num[NumW-1] ? MagW'(-num) : MagW'(num);
	assign d_abs   = den[NumW-1] ? MagW'(-den) : MagW'(den);
	assign shifted = {rem_q[MagW-1:0], n_q[MagW-1]};
	assign fits    = shifted >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == StepW'(DivSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= n_abs;
			d_q   <= d_abs;
			rem_q <= '0;
			q_q   <= '0;
			neg_q <= num[NumW-1] ^ den[NumW-1];
		end else if (busy_q) begin
			n_q   <= {n_q[MagW-2:0], 1'b0};
			rem_q <= fits ? shifted - {1'b0, d_q} : shifted;
			q_q   <= {q_q[DivSteps-2:0], fits};
		end
	end

	// Any quotient bit at or above 2^32 clamps to the 2^32 marker.
	assign mag = (|q_q[DivSteps-1:QuotW-1]) ? {1'b1, {(QuotW-1){1'b0}}}
		: QuotW'(q_q[QuotW-2:0]);

	always_comb begin
		if (neg_q) begin
			quot = (mag > QuotW'(33'h0_8000_0000)) ? {1'b1, {(OutW-1){1'b0}}}
				: OutW'(-mag);
		end else begin
			quot = (mag > QuotW'(33'h0_7FFF_FFFF)) ? {1'b0, {(OutW-1){1'b1}}}
				: OutW'(mag);
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign ctl.done  = done_q;

endmodule
